// ===== hdl/gssq_pkg.sv =====
// Shared constants, state type and helpers for the generator start/stop sequencer.
`timescale 1ns / 1ps

package gssq_pkg;

    localparam int TICK_W    = 17;
    localparam int VALUE_W   = 32;
    localparam int PERR_W    = 31;
    localparam int CODE_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 8;

    localparam logic [TICK_W-1:0]  TICK_MAX           = '1;
    localparam logic [TICK_W-1:0]  START_TIMEOUT_RST  = TICK_W'(30000);
    localparam logic [TICK_W-1:0]  STOP_TIMEOUT_RST   = TICK_W'(90000);
    localparam logic signed [VALUE_W-1:0] LOAD_VOLT_RST = '0;
    localparam logic [PERR_W-1:0]  POWER_ERR_RST      = PERR_W'(3355443);

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TIMEOUT = 2'd0,
        CFG_STOP_TIMEOUT  = 2'd1,
        CFG_LOAD_VOLTAGE  = 2'd2,
        CFG_POWER_ERROR   = 2'd3
    } cfg_index_t;

    // Reported state codes
    localparam logic [CODE_W-1:0] CODE_INIT     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_STOPPED  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_STARTING = 3'd2;
    localparam logic [CODE_W-1:0] CODE_RUNNING  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_STOPPING = 3'd4;

    typedef enum logic [4:0] {
        ST_INIT     = 5'b00001,
        ST_STOPPED  = 5'b00010,
        ST_STARTING = 5'b00100,
        ST_RUNNING  = 5'b01000,
        ST_STOPPING = 5'b10000
    } seq_state_t;

    function automatic logic [CODE_W-1:0] state_code(input seq_state_t st);
        logic [CODE_W-1:0] code;
        code = CODE_INIT;
        unique case (st)
            ST_INIT:     code = CODE_INIT;
            ST_STOPPED:  code = CODE_STOPPED;
            ST_STARTING: code = CODE_STARTING;
            ST_RUNNING:  code = CODE_RUNNING;
            ST_STOPPING: code = CODE_STOPPING;
            default:     code = CODE_INIT;
        endcase
        return code;
    endfunction

    // Saturating tick increment
    function automatic logic [TICK_W-1:0] tick_inc(input logic [TICK_W-1:0] cnt);
        return (cnt == TICK_MAX) ? cnt : cnt + TICK_W'(1);
    endfunction

endpackage

// ===== hdl/generator_start_stop_sequencer_top.sv =====
// Top level of the generator start/stop sequencer.
`timescale 1ns / 1ps

// Generator start/stop sequencer. Each input transfer is one millisecond tick
// carrying one-shot on/off commands, the generator running flag, DC-link
// voltage, power reference and measured power. The block steps a five-state
// sequencer (init, stopped, starting, running, stopping) and returns exactly
// one output transfer per tick with the start command, the generator-on flag,
// that tick's no-power alarm and the state code (0 init .. 4 stopping).
// Entry actions run on the first tick spent in a state. Starting and stopping
// time out once the saturating tick counter exceeds the configured limit; the
// timeout wins over the running flag. A limit of 131071 never expires.
// Rate: one tick per clock cycle sustained while m_axis_tready stays high. A tick
// is held in the input register, and the sequencer update runs in the cycle it
// moves to the output register, which drives the output transfer.
// The output register decouples the two sides: a new tick is taken while a
// result still waits, as long as the input register is empty or can move on.
// Configuration: write enable, index and data; index 0 start timeout, 1 stop
// timeout, 2 load voltage threshold (signed), 3 power error threshold. Write
// only while no tick is in flight.
module generator_start_stop_sequencer_top
    import gssq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // slave side
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] cmd_on, [1] cmd_off, [2] gen_running, [34:3] dc_voltage,
    // [66:35] power_reference, [98:67] power_measured, [103:99] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // master side
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] start_command, [1] generator_on, [2] no_power_alarm,
    // [5:3] state_code, [7:6] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    // configuration registers
    logic [TICK_W-1:0]         start_timeout_reg;
    logic [TICK_W-1:0]         stop_timeout_reg;
    logic signed [VALUE_W-1:0] load_voltage_reg;
    logic [PERR_W-1:0]         power_error_reg;

    // input stage
    logic                      in_valid_reg;
    logic                      cmd_on_reg;
    logic                      cmd_off_reg;
    logic                      gen_running_reg;
    logic signed [VALUE_W-1:0] dc_voltage_reg;
    logic signed [VALUE_W-1:0] power_reference_reg;
    logic signed [VALUE_W-1:0] power_measured_reg;

    // sequencer state
    seq_state_t        state_reg, state_next;
    logic              entry_reg, entry_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic              start_cmd_reg, start_cmd_next;
    logic              gen_on_reg, gen_on_next;
    logic              alarm_next;

    // output stage
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic advance;
    logic take_in;

    // datapath for the alarm
    logic signed [VALUE_W:0] power_diff;
    logic [VALUE_W:0]        power_err;
    logic                    volt_low;
    logic                    err_high;
    logic [TICK_W-1:0]       tick_inc_val;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_timeout_reg <= START_TIMEOUT_RST;
            stop_timeout_reg  <= STOP_TIMEOUT_RST;
            load_voltage_reg  <= LOAD_VOLT_RST;
            power_error_reg   <= POWER_ERR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_TIMEOUT: start_timeout_reg <= cfg_data[TICK_W-1:0];
                CFG_STOP_TIMEOUT:  stop_timeout_reg  <= cfg_data[TICK_W-1:0];
                CFG_LOAD_VOLTAGE:  load_voltage_reg  <= signed'(cfg_data[VALUE_W-1:0]);
                CFG_POWER_ERROR:   power_error_reg   <= cfg_data[PERR_W-1:0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            cmd_on_reg          <= s_axis_tdata[0];
            cmd_off_reg         <= s_axis_tdata[1];
            gen_running_reg     <= s_axis_tdata[2];
            dc_voltage_reg      <= signed'(s_axis_tdata[34:3]);
            power_reference_reg <= signed'(s_axis_tdata[66:35]);
            power_measured_reg  <= signed'(s_axis_tdata[98:67]);
        end
    end

    // |pref - pmeas| at 33 bits, never wraps
    assign power_diff = {power_reference_reg[VALUE_W-1], power_reference_reg}
                      - {power_measured_reg[VALUE_W-1], power_measured_reg};
    assign power_err  = power_diff[VALUE_W] ? (VALUE_W+1)'(0) - $unsigned(power_diff)
                                            : $unsigned(power_diff);
    assign volt_low   = dc_voltage_reg < load_voltage_reg;
    assign err_high   = power_err > {2'b00, power_error_reg};

    // counter starts over on entry, then counts this tick
    assign tick_inc_val = tick_inc(entry_reg ? '0 : tick_reg);

    // sequencer step for the tick in the input register
    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        start_cmd_next = start_cmd_reg;
        gen_on_next    = gen_on_reg;
        alarm_next     = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                if (entry_reg)
                    tick_next = '0;
                state_next = start_cmd_reg ? ST_STARTING : ST_STOPPED;
            end
            ST_STOPPED:
            begin
                if (entry_reg)
                    tick_next = '0;
                start_cmd_next = 1'b0;
                if (cmd_on_reg)
                    state_next = ST_STARTING;
            end
            ST_STARTING:
            begin
                if (entry_reg)
                    start_cmd_next = 1'b1;
                tick_next = tick_inc_val;
                if (gen_running_reg)
                    state_next = ST_RUNNING;
                if (tick_inc_val > start_timeout_reg)
                    state_next = ST_STOPPED;
            end
            ST_RUNNING:
            begin
                if (entry_reg)
                begin
                    tick_next   = '0;
                    gen_on_next = 1'b1;
                end
                alarm_next = volt_low && gen_running_reg && err_high;
                if (cmd_off_reg || !gen_running_reg)
                    state_next = ST_STOPPING;
            end
            ST_STOPPING:
            begin
                if (entry_reg)
                begin
                    gen_on_next    = 1'b0;
                    start_cmd_next = 1'b0;
                end
                tick_next = tick_inc_val;
                if (!gen_running_reg || (tick_inc_val > stop_timeout_reg))
                    state_next = ST_STOPPED;
            end
            default: ;
        endcase
        entry_next = (state_next != state_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            entry_reg     <= 1'b1;
            tick_reg      <= '0;
            start_cmd_reg <= 1'b0;
            gen_on_reg    <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            entry_reg     <= entry_next;
            tick_reg      <= tick_next;
            start_cmd_reg <= start_cmd_next;
            gen_on_reg    <= gen_on_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {2'b00, state_code(state_next), alarm_next,
                             gen_on_next, start_cmd_next};
    end

endmodule
